// File: design/asdu_pkg.sv
// Package for the store address and data unit.
// Holds the opcode, shift-kind and access-size codes shared by the RTL and checker.
package asdu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned ImmW = 12;
  localparam int unsigned AmtW = 5;

  localparam logic [XLEN-1:0] ByteMask = 32'h0000_00ff;
  localparam logic [XLEN-1:0] HalfMask = 32'h0000_ffff;
  localparam logic [XLEN-1:0] DwordStep = 32'd4;

  typedef enum logic [2:0] {
    OP_WORD_IMM = 3'd0,
    OP_WORD_REG = 3'd1,
    OP_BYTE_IMM = 3'd2,
    OP_BYTE_REG = 3'd3,
    OP_DWORD_IMM = 3'd4,
    OP_HALF_IMM = 3'd5,
    OP_HALF_REG = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    SH_LSL = 3'd0,
    SH_LSR = 3'd1,
    SH_ASR = 3'd2,
    SH_ROR = 3'd3,
    SH_RRX = 3'd4
  } shift_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } size_e;

endpackage

// File: design/asdu_shifter.sv
// Offset register shifter: LSL, LSR, ASR, ROR and RRX with carry in.
// Combinational; uses asdu_pkg for the shift-kind codes.
module asdu_shifter
  import asdu_pkg::*;
(
  input  logic [XLEN-1:0] value_i,
  input  logic [2:0]      kind_i,
  input  logic [AmtW-1:0] amount_i,
  input  logic            carry_i,
  output logic [XLEN-1:0] result_o
);

  logic [AmtW:0] ror_left;

  assign ror_left = (AmtW+1)'(XLEN) - {1'b0, amount_i};

  always_comb begin
    result_o = value_i;
    if (amount_i != '0) begin
      case (kind_i)
        SH_LSL:  result_o = value_i << amount_i;
        SH_LSR:  result_o = value_i >> amount_i;
        SH_ASR:  result_o = XLEN'($signed(value_i) >>> amount_i);
        SH_ROR:  result_o = (value_i >> amount_i) | (value_i << ror_left);
        // RRX rotates by one through carry for any nonzero amount
        SH_RRX:  result_o = {carry_i, value_i[XLEN-1:1]};
        default: result_o = value_i;
      endcase
    end
  end

endmodule

// File: design/arm_store_address_and_data_unit_top.sv
// An accepted request passes the stage 1, stage 2 and output registers before its
// first write on the output. Throughput: one request per cycle while stall_i is low;
// a doubleword store holds the output register for a second write beat as well.
// Stages: decode and offset shift, address add, output beat register.
// Reset clears all valid bits; no clearing pass.
module arm_store_address_and_data_unit_top
  import asdu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [2:0]          op_i,
  input  logic [XLEN-1:0]     base_value_i,
  input  logic [XLEN-1:0]     offset_reg_value_i,
  input  logic [XLEN-1:0]     store_value_i,
  input  logic [XLEN-1:0]     store_value_second_i,
  input  logic [ImmW-1:0]     immediate_i,
  input  logic                pre_index_i,
  input  logic                add_offset_i,
  input  logic                write_back_i,
  input  logic [2:0]          shift_kind_i,
  input  logic [AmtW-1:0]     shift_amount_i,
  input  logic                carry_in_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [XLEN-1:0]     write_address_o,
  output logic [XLEN-1:0]     write_data_o,
  output logic [1:0]          access_size_o,
  output logic                must_align_o,
  output logic                base_update_o,
  output logic [XLEN-1:0]     base_new_value_o,
  output logic                last_write_o
);

  // ---------------- decode ----------------
  logic [XLEN-1:0] shifted;
  logic            dec_ok;
  logic            dec_reg;
  logic            dec_dbl;
  size_e           dec_size;
  logic [XLEN-1:0] dec_data;

  asdu_shifter u_shifter (
    .value_i  (offset_reg_value_i),
    .kind_i   (shift_kind_i),
    .amount_i (shift_amount_i),
    .carry_i  (carry_in_i),
    .result_o (shifted)
  );

  always_comb begin
    dec_ok   = 1'b1;
    dec_reg  = 1'b0;
    dec_dbl  = 1'b0;
    dec_size = SZ_WORD;
    case (op_e'(op_i))
      OP_WORD_IMM:  dec_size = SZ_WORD;
      OP_WORD_REG:  dec_reg  = 1'b1;
      OP_BYTE_IMM:  dec_size = SZ_BYTE;
      OP_BYTE_REG: begin
        dec_reg  = 1'b1;
        dec_size = SZ_BYTE;
      end
      OP_DWORD_IMM: dec_dbl  = 1'b1;
      OP_HALF_IMM:  dec_size = SZ_HALF;
      OP_HALF_REG: begin
        dec_reg  = 1'b1;
        dec_size = SZ_HALF;
      end
      default:      dec_ok   = 1'b0;
    endcase
    case (dec_size)
      SZ_BYTE: dec_data = store_value_i & ByteMask;
      SZ_HALF: dec_data = store_value_i & HalfMask;
      default: dec_data = store_value_i;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_q, s2_valid_q, out_valid_q, out_first_q;
  logic out_free, s2_free, s1_free;

  // output register takes a new item unless it holds a stalled write or a first doubleword word
  assign out_free = !out_valid_q || (!stall_i && !out_first_q);
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign stall_o  = !s1_free;

  // ---------------- stage 1: decoded operands ----------------
  logic [XLEN-1:0] s1_base_q, s1_off_q, s1_data_q, s1_data2_q;
  logic            s1_sub_q, s1_pre_q, s1_upd_q, s1_dbl_q;
  size_e           s1_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      // drop unused opcodes here: they produce no write
      s1_valid_q <= valid_i && dec_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_base_q  <= base_value_i;
      s1_off_q   <= dec_reg ? shifted : XLEN'(immediate_i);
      s1_sub_q   <= !dec_reg && !add_offset_i;
      s1_pre_q   <= dec_reg || pre_index_i;
      s1_upd_q   <= !dec_reg && write_back_i;
      s1_data_q  <= dec_data;
      s1_data2_q <= store_value_second_i;
      s1_dbl_q   <= dec_dbl;
      s1_size_q  <= dec_size;
    end
  end

  // ---------------- stage 2: address ----------------
  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] s2_addr_q, s2_newv_q, s2_data_q, s2_data2_q;
  logic            s2_upd_q, s2_dbl_q;
  size_e           s2_size_q;

  assign sum = s1_sub_q ? (s1_base_q - s1_off_q) : (s1_base_q + s1_off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_addr_q  <= s1_pre_q ? sum : s1_base_q;
      s2_newv_q  <= s1_upd_q ? sum : '0;
      s2_upd_q   <= s1_upd_q;
      s2_data_q  <= s1_data_q;
      s2_data2_q <= s1_data2_q;
      s2_dbl_q   <= s1_dbl_q;
      s2_size_q  <= s1_size_q;
    end
  end

  // ---------------- stage 3: output beats ----------------
  logic [XLEN-1:0] out_addr_q, out_data_q, out_newv_q;
  logic [XLEN-1:0] hold_data2_q, hold_newv_q;
  logic            out_upd_q, out_last_q, out_align_q, hold_upd_q;
  size_e           out_size_q;
  logic            second_beat;

  assign second_beat = out_valid_q && out_first_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_first_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
      out_first_q <= s2_valid_q && s2_dbl_q;
    end else if (second_beat) begin
      out_first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_addr_q   <= s2_addr_q;
      out_data_q   <= s2_data_q;
      out_size_q   <= s2_size_q;
      out_align_q  <= s2_dbl_q;
      out_upd_q    <= s2_dbl_q ? 1'b0 : s2_upd_q;
      out_newv_q   <= s2_dbl_q ? '0 : s2_newv_q;
      out_last_q   <= !s2_dbl_q;
      hold_data2_q <= s2_data2_q;
      hold_upd_q   <= s2_upd_q;
      hold_newv_q  <= s2_newv_q;
    end else if (second_beat) begin
      // advance to the second doubleword word; writeback rides here
      out_addr_q <= out_addr_q + DwordStep;
      out_data_q <= hold_data2_q;
      out_upd_q  <= hold_upd_q;
      out_newv_q <= hold_newv_q;
      out_last_q <= 1'b1;
    end
  end

  assign valid_o          = out_valid_q;
  assign write_address_o  = out_addr_q;
  assign write_data_o     = out_data_q;
  assign access_size_o    = out_size_q;
  assign must_align_o     = out_align_q;
  assign base_update_o    = out_upd_q;
  assign base_new_value_o = out_newv_q;
  assign last_write_o     = out_last_q;

endmodule

// File: design/asdu_checker.sv
// Port-level checker for the store address and data unit, bound to the top level.
// Uses asdu_pkg for the access-size codes.
module asdu_checker
  import asdu_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            valid_o,
  input logic            stall_i,
  input logic [XLEN-1:0] write_address_o,
  input logic [1:0]      access_size_o,
  input logic            must_align_o,
  input logic            base_update_o,
  input logic [XLEN-1:0] base_new_value_o,
  input logic            last_write_o
);

  // only the first doubleword word is a non-final write, and it is aligned
  a_nonlast_is_dword: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_write_o |-> must_align_o && access_size_o == SZ_WORD)
    else $error("non-final write is not a doubleword word");

  a_upd_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (base_update_o || base_new_value_o != '0) |-> last_write_o
      && (base_update_o || base_new_value_o == '0))
    else $error("writeback outside the final write or value without update");

  // second doubleword word follows at address plus four
  a_dword_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_write_o && !stall_i |=> valid_o && last_write_o && must_align_o
      && write_address_o == $past(write_address_o) + DwordStep)
    else $error("second doubleword write missing or misplaced");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(write_address_o) && $stable(last_write_o))
    else $error("stalled write changed");

endmodule

bind arm_store_address_and_data_unit_top asdu_checker u_asdu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_o          (valid_o),
  .stall_i          (stall_i),
  .write_address_o  (write_address_o),
  .access_size_o    (access_size_o),
  .must_align_o     (must_align_o),
  .base_update_o    (base_update_o),
  .base_new_value_o (base_new_value_o),
  .last_write_o     (last_write_o)
);
